[rtl/bole_pkg.sv]
`default_nettype none

package bole_pkg;

    // command codes
    localparam logic [2:0] CMD_INS_HEAD  = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [2:0] CMD_INS_AFTER = 3'd2;
    localparam logic [2:0] CMD_DEL_HEAD  = 3'd3;
    localparam logic [2:0] CMD_DEL_TAIL  = 3'd4;
    localparam logic [2:0] CMD_DEL_VALUE = 3'd5;
    localparam logic [2:0] CMD_DISPLAY   = 3'd6;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ELEMENT   = 2'd3;

    localparam int unsigned DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DISPLAY
    } state_t;

endpackage

`default_nettype wire

[rtl/bounded_ordered_list_engine_core.sv]
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, held head to tail in
// one single-port-write, registered-read RAM.
// A request is taken at a rising edge with start high and busy low; command,
// search_key and operand_value are sampled at that edge. Results appear on
// status, element, list_length and final_item for exactly one cycle, marked
// by result_valid; the receiver has no way to hold them off.
// Request handling, with N the number of entries held:
//   insert at tail, delete at tail, unused code, any failing request on an
//   empty or full list: result in the cycle after the request
//   insert at head, delete at head: RAM shift sweep over the list
//   insert after key / delete value: key scan of up to N entries, then a
//   shift sweep over the entries behind the match
//   display: elements head to tail, one per cycle
// The RAM read latency sets the pace: the scan and the shift each move one
// entry per cycle. busy stays high until the last result is issued; the next
// request may be taken in the cycle the last result is shown.
// Reset clears the entry count and control state; RAM contents need no clearing pass.
module bounded_ordered_list_engine_core
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [2:0]                          command,
    input  wire logic signed [31:0]                  search_key,
    input  wire logic signed [31:0]                  operand_value,
    output logic                                     result_valid,
    output logic [1:0]                               status,
    output logic signed [31:0]                       element,
    output logic [$clog2(CAPACITY + 1)-1:0]          list_length,
    output logic                                     final_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t          state_reg, state_next;
    logic [2:0]      cmd_reg, cmd_next;
    data_t           key_reg, key_next;
    data_t           val_reg, val_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            pend_reg, pend_next;
    logic            more_reg, more_next;

    logic            res_vld_reg, res_vld_next;
    logic [1:0]      res_status_reg, res_status_next;
    data_t           res_elem_reg, res_elem_next;
    logic [CW-1:0]   res_len_reg, res_len_next;
    logic            res_final_reg, res_final_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    data_t           ram_wdata;
    logic [AW-1:0]   ram_raddr;
    data_t           ram_rdata;

    logic [CW-1:0]   count_m1;
    logic            full;
    logic            pidx_last;
    data_t           target;

    bole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_m1  = count_reg - CW'(1);
    assign full      = (count_reg == CAP_C);
    assign pidx_last = (CW'(pidx_reg) == count_m1);
    assign target    = (cmd_reg == CMD_INS_AFTER) ? key_reg : val_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            more_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            more_reg    <= more_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload and pointers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        pidx_reg       <= pidx_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_elem_reg   <= res_elem_next;
        res_len_reg    <= res_len_next;
        res_final_reg  <= res_final_next;
    end

    // sequencer: next state, RAM access and results
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pidx_next       = pidx_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        more_next       = more_reg;

        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = val_reg;
        ram_raddr       = ptr_reg[AW-1:0];

        res_vld_next    = 1'b0;
        res_status_next = ST_DONE;
        res_elem_next   = '0;
        res_final_next  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    key_next  = data_t'(search_key);
                    val_next  = data_t'(operand_value);
                    pend_next = 1'b0;
                    more_next = 1'b0;
                    ptr_next  = '0;
                    unique case (command)
                        CMD_INS_HEAD:
                        begin
                            if (full)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = '0;
                                ram_wdata       = data_t'(operand_value);
                                count_next      = count_reg + CW'(1);
                                res_vld_next    = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SHIFT_UP;
                                pos_next   = '0;
                                ptr_next   = count_m1;
                                more_next  = 1'b1;
                            end
                        end
                        CMD_INS_TAIL:
                        begin
                            if (full)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = count_reg[AW-1:0];
                                ram_wdata    = data_t'(operand_value);
                                count_next   = count_reg + CW'(1);
                                res_vld_next = 1'b1;
                            end
                        end
                        CMD_INS_AFTER:
                        begin
                            if (full)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_DEL_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_NOT_FOUND;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next   = '0;
                                res_vld_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SHIFT_DOWN;
                                pos_next   = '0;
                                ptr_next   = CW'(1);
                                more_next  = 1'b1;
                            end
                        end
                        CMD_DEL_TAIL:
                        begin
                            res_vld_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        CMD_DEL_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_vld_next    = 1'b1;
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_DISPLAY;
                            end
                        end
                        default:
                        begin
                            res_vld_next = 1'b1;
                        end
                    endcase
                end
            end

            // scan from the head for the first matching entry
            S_SEARCH:
            begin
                if (pend_reg && (ram_rdata == target))
                begin
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_INS_AFTER)
                    begin
                        if (pidx_last)
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = pidx_reg + AW'(1);
                            count_next   = count_reg + CW'(1);
                            res_vld_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_UP;
                            pos_next   = pidx_reg + AW'(1);
                            ptr_next   = count_m1;
                            more_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pidx_last)
                        begin
                            count_next   = count_m1;
                            res_vld_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_DOWN;
                            pos_next   = pidx_reg;
                            ptr_next   = CW'(pidx_reg) + CW'(1);
                            more_next  = 1'b1;
                        end
                    end
                end
                else if (pend_reg && pidx_last)
                begin
                    pend_next       = 1'b0;
                    res_vld_next    = 1'b1;
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else if (ptr_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // move entries one place towards the tail, then drop the new value in
            S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (more_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    if (ptr_reg[AW-1:0] == pos_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - CW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!more_reg && !pend_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = pos_reg;
                    ram_wdata    = val_reg;
                    count_next   = count_reg + CW'(1);
                    res_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // move entries behind the removed one place towards the head
            S_SHIFT_DOWN:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (more_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    if (ptr_reg == count_m1)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!more_reg && !pend_reg)
                begin
                    count_next   = count_m1;
                    res_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // stream entries head to tail, one per cycle
            S_DISPLAY:
            begin
                if (pend_reg)
                begin
                    res_vld_next    = 1'b1;
                    res_status_next = ST_ELEMENT;
                    res_elem_next   = ram_rdata;
                    res_final_next  = pidx_last;
                    if (pidx_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_len_next = count_next;
    end

    // outputs
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_vld_reg;
    assign status       = res_status_reg;
    assign element      = res_elem_reg;
    assign list_length  = res_len_reg;
    assign final_item   = res_final_reg;

endmodule

`default_nettype wire

[rtl/bole_ram.sv]
`default_nettype none

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/bole_checker.sv]
`default_nettype none

module bole_checker
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        busy,
    input  wire logic                        result_valid,
    input  wire logic [1:0]                  status,
    input  wire logic signed [31:0]          element,
    input  wire logic [$clog2(CAPACITY + 1)-1:0] list_length,
    input  wire logic                        final_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // list never grows past capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (list_length <= CAP_C))
        else $error("list length beyond capacity");

    // a dropped insert only ever happens on a full list
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_FULL)) |-> (list_length == CAP_C))
        else $error("full status with list not full");

    // element is zero on all non-display results
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_ELEMENT)) |-> (element == '0))
        else $error("element not zero outside display");

    // display stream runs without gaps until its last element
    a_disp_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_item) |=>
            (result_valid && (status == ST_ELEMENT)))
        else $error("display stream broken");

    // only display elements can be non-final
    a_nonfinal: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_item) |-> (status == ST_ELEMENT && busy))
        else $error("non-final result outside display");

endmodule

bind bounded_ordered_list_engine_core bole_checker #(
    .CAPACITY (CAPACITY)
) u_bole_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .element      (element),
    .list_length  (list_length),
    .final_item   (final_item)
);

`default_nettype wire

[tb/sv/list_result_checker.sv]
`default_nettype none

module list_result_checker
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [2:0]                      command,
    input  wire logic signed [31:0]              search_key,
    input  wire logic signed [31:0]              operand_value,
    input  wire logic                            result_valid,
    input  wire logic [1:0]                      status,
    input  wire logic signed [31:0]              element,
    input  wire logic [$clog2(CAPACITY + 1)-1:0] list_length,
    input  wire logic                            final_item,
    output int                                   fail_count,
    output int                                   outstanding,
    output int                                   results_checked,
    output int                                   full_drops
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [1:0]       status;
        data_t            element;
        logic [LEN_W-1:0] length;
        logic             last;
    } list_result_t;

    // shadow of the list, index 0 is the head
    data_t        held [CAPACITY];
    int           held_count = 0;
    list_result_t expected_results [$];
    int           errors = 0;
    int           checked = 0;
    int           drops = 0;

    function automatic int find_first(input data_t v);
        for (int i = 0; i < held_count; i++)
            if (held[i] == v)
                return i;
        return -1;
    endfunction

    // make room at pos by moving everything behind it one place down
    function automatic void open_gap(input int pos);
        for (int i = held_count; i > pos; i--)
            held[i] = held[i - 1];
        held_count++;
    endfunction

    function automatic void close_gap(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
            held[i] = held[i + 1];
        held_count--;
    endfunction

    function automatic void apply_list_command(input logic [2:0] cmd, input data_t key,
                                               input data_t val);
        list_result_t res;
        int           pos;
        bit           full;
        full        = held_count >= CAPACITY;
        res.status  = ST_DONE;
        res.element = '0;
        res.last    = 1'b1;
        case (cmd)
            CMD_INS_HEAD, CMD_INS_TAIL:
            begin
                if (full)
                    res.status = ST_FULL;
                else if (cmd == CMD_INS_HEAD)
                begin
                    open_gap(0);
                    held[0] = val;
                end
                else
                begin
                    held[held_count] = val;
                    held_count++;
                end
            end
            CMD_INS_AFTER:
            begin
                // a full list is refused even if the key is present
                pos = find_first(key);
                if (full)
                    res.status = ST_FULL;
                else if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    open_gap(pos + 1);
                    held[pos + 1] = val;
                end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL:
            begin
                if (held_count == 0)
                    res.status = ST_NOT_FOUND;
                else
                    close_gap(cmd == CMD_DEL_HEAD ? 0 : held_count - 1);
            end
            CMD_DEL_VALUE:
            begin
                pos = find_first(val);
                if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                    close_gap(pos);
            end
            CMD_DISPLAY:
            begin
                if (held_count == 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    // one result per entry, head first
                    for (int i = 0; i < held_count; i++)
                    begin
                        res.status  = ST_ELEMENT;
                        res.element = held[i];
                        res.length  = LEN_W'(held_count);
                        res.last    = (i + 1 == held_count);
                        expected_results.push_back(res);
                    end
                    return;
                end
            end
            default:
                ;
        endcase
        if (res.status == ST_FULL)
            drops++;
        res.length = LEN_W'(held_count);
        expected_results.push_back(res);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            expected_results.delete();
        end
        else
        begin
            // results first: they always belong to an earlier request
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0h element %0h",
                             $time, status, element);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("element", want.element, element);
                    check_field("list_length", 32'(want.length), 32'(list_length));
                    check_field("final_item", 32'(want.last), 32'(final_item));
                    checked++;
                end
            end
            if (start && !busy)
                apply_list_command(command, search_key, operand_value);
        end
        fail_count      <= errors;
        outstanding     <= expected_results.size();
        results_checked <= checked;
        full_drops      <= drops;
    end

endmodule

`default_nettype wire

[tb/sv/tb_bounded_ordered_list_engine_core.sv]
`default_nettype none

module tb_bounded_ordered_list_engine_core;
    import bole_pkg::*;

    localparam int         CAPACITY     = 16;
    localparam int         LEN_W        = $clog2(CAPACITY + 1);
    localparam int         RANDOM_ITEMS = 104;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [2:0]              command = CMD_INS_HEAD;
    logic signed [31:0]      search_key = '0;
    logic signed [31:0]      operand_value = '0;
    logic                    busy;
    logic                    result_valid;
    logic [1:0]              status;
    logic signed [31:0]      element;
    logic [LEN_W-1:0]        list_length;
    logic                    final_item;

    int    fail_count;
    int    outstanding;
    int    results_checked;
    int    full_drops;
    int    cycles = 0;
    int    requests_sent = 0;
    int    directed_sent = 0;
    int    random_sent = 0;
    int    code_hits [8];
    bit    burst = 1'b0;
    bit    growing = 1'b0;
    data_t value_pool [8];

    bounded_ordered_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .search_key   (search_key),
        .operand_value(operand_value),
        .result_valid (result_valid),
        .status       (status),
        .element      (element),
        .list_length  (list_length),
        .final_item   (final_item)
    );

    list_result_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .search_key     (search_key),
        .operand_value  (operand_value),
        .result_valid   (result_valid),
        .status         (status),
        .element        (element),
        .list_length    (list_length),
        .final_item     (final_item),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .full_drops     (full_drops)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // pool values repeat often so keys and deletes tend to hit
    function automatic data_t pick_value();
        if ($urandom_range(0, 99) < 70)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_command(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow)
        begin
            if (r < 22) return CMD_INS_HEAD;
            if (r < 44) return CMD_INS_TAIL;
            if (r < 66) return CMD_INS_AFTER;
            if (r < 72) return CMD_DEL_HEAD;
            if (r < 78) return CMD_DEL_TAIL;
            if (r < 86) return CMD_DEL_VALUE;
        end
        else
        begin
            if (r < 5)  return CMD_INS_HEAD;
            if (r < 10) return CMD_INS_TAIL;
            if (r < 16) return CMD_INS_AFTER;
            if (r < 36) return CMD_DEL_HEAD;
            if (r < 56) return CMD_DEL_TAIL;
            if (r < 86) return CMD_DEL_VALUE;
        end
        if (r < 97) return CMD_DISPLAY;
        return CMD_UNUSED;
    endfunction

    // hold the request until it is taken, then maybe leave a gap
    task automatic issue(input logic [2:0] cmd, input data_t key, input data_t val);
        int idle;
        start         <= 1'b1;
        command       <= cmd;
        search_key    <= key;
        operand_value <= val;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        code_hits[cmd]++;
        idle = idle_cycles();
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [2:0] cmd;
        foreach (code_hits[i])
            code_hits[i] = 0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 8; i++)
            value_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // everything on an empty list
        issue(CMD_DISPLAY, '0, '0);
        issue(CMD_DEL_HEAD, '0, '0);
        issue(CMD_DEL_TAIL, '0, '0);
        issue(CMD_DEL_VALUE, '0, 32'h8000_0000);
        issue(CMD_INS_AFTER, 32'h7fff_ffff, 32'h0000_0001);
        issue(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);

        // extremes, key hits and misses
        issue(CMD_INS_TAIL, '0, 32'h7fff_ffff);
        issue(CMD_INS_HEAD, '0, 32'h8000_0000);
        issue(CMD_INS_AFTER, 32'h8000_0000, 32'h0000_0000);
        issue(CMD_INS_AFTER, 32'h7fff_ffff, 32'hffff_ffff);
        issue(CMD_INS_AFTER, 32'h5555_aaaa, 32'h1234_5678);
        issue(CMD_DEL_VALUE, '0, 32'haaaa_5555);
        issue(CMD_DEL_VALUE, '0, 32'h0000_0000);
        issue(CMD_DISPLAY, '0, '0);

        // fill to capacity, then hit the full list with every insert
        repeat (CAPACITY - 3)
            issue(CMD_INS_TAIL, '0, $urandom());
        issue(CMD_INS_HEAD, '0, 32'h0000_0001);
        issue(CMD_INS_TAIL, '0, 32'h0000_0001);
        issue(CMD_INS_AFTER, 32'h1234_5678, 32'h0000_0001);
        issue(CMD_DISPLAY, '0, '0);
        issue(CMD_DEL_TAIL, '0, '0);
        issue(CMD_DEL_HEAD, '0, '0);
        directed_sent = requests_sent;

        // random phases that alternately grow and drain the list
        while (random_sent < RANDOM_ITEMS)
        begin
            growing = !growing;
            burst   = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(10, 30))
            begin
                if (random_sent < RANDOM_ITEMS)
                begin
                    cmd = pick_command(growing);
                    issue(cmd, pick_value(), pick_value());
                    if (cmd != CMD_UNUSED)
                        random_sent++;
                end
            end
        end
        burst = 1'b0;
        start <= 1'b0;

        // drain, then give stray results time to show up
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (3 * CAPACITY + 8) @(posedge clk);

        $display("%0d requests (%0d directed), %0d results checked, %0d inserts refused as full",
                 requests_sent, directed_sent, results_checked, full_drops);
        $display("requests per command code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 code_hits[0], code_hits[1], code_hits[2], code_hits[3],
                 code_hits[4], code_hits[5], code_hits[6], code_hits[7]);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
